FILE: rtl/core/lpc_pkg.sv
// Shared types and constants for the laser parallelogram collision block.
// Beat layouts, configuration register codes, queue entry and status structs.
// No dependencies.
package lpc_pkg;

  // Beam range width
  localparam int RANGE_BITS = 16;

  // Compare width for the edge tests (covers 2*r*q and -(AY*cs))
  localparam int CMP_W = (RANGE_BITS + 35 > 52) ? RANGE_BITS + 35 : 52;
  // Width of r*bc
  localparam int RBC_W = RANGE_BITS + 17;
  // Width of ss*bc - cs*bs
  localparam int Q_W = 33;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_SINE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_COSINE = 3'd4;

  localparam logic [15:0]        RST_THRESHOLD    = 16'd1000;
  localparam logic [15:0]        RST_WIDTH        = 16'd500;
  localparam logic [15:0]        RST_LENGTH       = 16'd500;
  localparam logic signed [15:0] RST_STEER_SINE   = 16'sd0;
  localparam logic signed [15:0] RST_STEER_COSINE = 16'sd32767;

  // Hit tally saturation
  localparam logic [1:0] HITS_MAX = 2'd2;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range_mm;
    logic signed [15:0]    beam_sine;
    logic signed [15:0]    beam_cosine;
    logic                  last_beam;
  } lpc_beam_t;

  typedef struct packed {
    logic       collision;
    logic [1:0] hits_seen;
  } lpc_result_t;

  // Classified beam, front to back
  typedef struct packed {
    logic                    in_range;
    logic                    last;
    logic [RANGE_BITS-1:0]   r;
    logic signed [Q_W-1:0]   q;
    logic signed [RBC_W-1:0] rbc;
    logic                    bc_pos;
    logic                    bc_neg;
  } lpc_entry_t;

  // Configuration and derived geometry
  typedef struct packed {
    logic                    busy;
    logic [15:0]             threshold;
    logic signed [15:0]      steer_sine;
    logic signed [15:0]      steer_cosine;
    logic                    d_pos;
    logic                    d_neg;
    logic signed [CMP_W-1:0] ay_cs_neg;
    logic signed [CMP_W-1:0] w_cs;
    logic signed [CMP_W-1:0] t_cs;
  } lpc_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lpc_qstat_t;

endpackage

FILE: rtl/core/laser_parallelogram_collision.sv
// Top level of the laser parallelogram collision block.
// Depends on lpc_pkg, lpc_cfg, lpc_front, lpc_queue, lpc_back.
//
//   channel  | handshake                 | payload
//   beam     | beam_valid / beam_stall   | lpc_beam_t: range, beam sine/cosine, last
//   result   | result_valid/result_stall | lpc_result_t: collision, hits_seen
//   config   | cfg_we                    | cfg_index, cfg_data
//
// Front end takes one beam per cycle into a two-entry queue while beam_stall is low;
// the back end pops a beam, does the 2*r*q multiply, then the edge compare, and pops
// the next beam only after that, so it sets the sustained rate.
// After reset and after each configuration write, beam_stall stays high
// while the settle counter runs down and the geometry products settle.
// A result waiting in the output register blocks only a later last beam.
module laser_parallelogram_collision import lpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  beam_valid,
  output logic                  beam_stall,
  input  lpc_beam_t             beam,
  output logic                  result_valid,
  input  logic                  result_stall,
  output lpc_result_t           result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lpc_cfg_t   cfg;
  lpc_qstat_t qstat;
  lpc_entry_t wr_entry;
  lpc_entry_t head;
  logic       push;
  logic       pop;

  lpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpc_front u_front (
    .beam       (beam),
    .beam_valid (beam_valid),
    .beam_stall (beam_stall),
    .cfg        (cfg),
    .qstat      (qstat),
    .push       (push),
    .entry      (wr_entry)
  );

  lpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .qstat    (qstat)
  );

  lpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // a config write holds off beams while geometry settles
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> beam_stall)
    else $error("beam accepted right after a config write");

  // never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("queue overflow");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    qstat.empty |-> !pop)
    else $error("queue underflow");

  // collision flag agrees with the saturated tally
  a_flag_tally: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.collision == (result.hits_seen == HITS_MAX)))
    else $error("collision flag disagrees with hit count");

endmodule

FILE: rtl/core/lpc_cfg.sv
// Configuration registers and derived parallelogram geometry.
// Depends on lpc_pkg.
module lpc_cfg import lpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output lpc_cfg_t              cfg
);

  logic [15:0]        threshold;
  logic [15:0]        width;
  logic [15:0]        length;
  logic signed [15:0] steer_sine;
  logic signed [15:0] steer_cosine;
  logic [1:0]         settle_cnt;

  // derived terms, recomputed every cycle
  logic signed [32:0] l_ss;
  logic signed [32:0] w_cs;
  logic signed [32:0] t_cs;
  logic signed [33:0] ay;
  logic signed [33:0] d;
  logic signed [49:0] ay_cs;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= RST_THRESHOLD;
      width        <= RST_WIDTH;
      length       <= RST_LENGTH;
      steer_sine   <= RST_STEER_SINE;
      steer_cosine <= RST_STEER_COSINE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold    <= cfg_data;
        REG_WIDTH:        width        <= cfg_data;
        REG_LENGTH:       length       <= cfg_data;
        REG_STEER_SINE:   steer_sine   <= $signed(cfg_data);
        REG_STEER_COSINE: steer_cosine <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // settle counter: holds busy after reset and after every write while the derived terms catch up
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_cnt <= 2'd3;
    end else if (cfg_we) begin
      settle_cnt <= 2'd3;
    end else if (settle_cnt != 2'd0) begin
      settle_cnt <= settle_cnt - 2'd1;
    end
  end

  // geometry pipeline: products, corner sums, then AY*cs
  always_ff @(posedge clk) begin
    l_ss  <= $signed({1'b0, length}) * steer_sine;
    w_cs  <= $signed({1'b0, width}) * steer_cosine;
    t_cs  <= $signed({1'b0, threshold}) * steer_cosine;
    ay    <= $signed({3'b000, width, 15'd0}) + 34'(l_ss <<< 1);
    d     <= $signed({2'b00, width, 16'd0}) + 34'(l_ss <<< 1);
    ay_cs <= ay * steer_cosine;
  end

  assign cfg.busy         = (settle_cnt != 2'd0);
  assign cfg.threshold    = threshold;
  assign cfg.steer_sine   = steer_sine;
  assign cfg.steer_cosine = steer_cosine;
  assign cfg.d_pos        = !d[33] && (d != 34'sd0);
  assign cfg.d_neg        = d[33];
  assign cfg.ay_cs_neg    = -CMP_W'(ay_cs);
  assign cfg.w_cs         = CMP_W'(w_cs) <<< 15;
  assign cfg.t_cs         = CMP_W'(t_cs);

endmodule

FILE: rtl/core/lpc_front.sv
// Front end: accepts beam beats, checks range, forms the beam products.
// Depends on lpc_pkg.
module lpc_front import lpc_pkg::*; (
  input  lpc_beam_t  beam,
  input  logic       beam_valid,
  output logic       beam_stall,
  input  lpc_cfg_t   cfg,
  input  lpc_qstat_t qstat,
  output logic       push,
  output lpc_entry_t entry
);

  localparam int RW = (RANGE_BITS > 16) ? RANGE_BITS : 16;
  localparam logic [RW-1:0] MIN_RANGE = RW'(10);

  logic [RW-1:0]      r_ext;
  logic [RW-1:0]      t_ext;
  logic signed [31:0] ss_bc;
  logic signed [31:0] cs_bs;

  // flow control
  assign beam_stall = cfg.busy || qstat.full;
  assign push       = beam_valid && !beam_stall;

  // classify
  always_comb begin
    r_ext = RW'(beam.range_mm);
    t_ext = RW'(cfg.threshold);
    ss_bc = cfg.steer_sine * beam.beam_cosine;
    cs_bs = cfg.steer_cosine * beam.beam_sine;

    entry.in_range = (r_ext > MIN_RANGE) && (r_ext < t_ext);
    entry.last     = beam.last_beam;
    entry.r        = beam.range_mm;
    entry.q        = Q_W'(ss_bc) - Q_W'(cs_bs);
    entry.rbc      = $signed({1'b0, beam.range_mm}) * beam.beam_cosine;
    entry.bc_pos   = !beam.beam_cosine[15] && (beam.beam_cosine != 16'sd0);
    entry.bc_neg   = beam.beam_cosine[15];
  end

endmodule

FILE: rtl/core/lpc_queue.sv
// Two-entry queue between the front end and the evaluation back end.
// Depends on lpc_pkg.
module lpc_queue import lpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lpc_entry_t wr_entry,
  input  logic       pop,
  output lpc_entry_t rd_entry,
  output lpc_qstat_t qstat
);

  lpc_entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign rd_entry    = mem[rd_ptr];
  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);

endmodule

FILE: rtl/core/lpc_back.sv
// Back end: edge tests, hit tally and the result register.
// Depends on lpc_pkg.
module lpc_back import lpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  lpc_cfg_t    cfg,
  input  lpc_qstat_t  qstat,
  input  lpc_entry_t  head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output lpc_result_t result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

  logic [1:0]              st;
  logic [1:0]              st_next;
  lpc_entry_t              cur;
  logic signed [CMP_W-1:0] lhs;
  logic                    x_pos;
  logic                    x_neg;
  logic [1:0]              hit_tally;
  logic [1:0]              tally_next;
  logic                    hit;
  logic                    out_free;
  logic                    finish;
  logic signed [CMP_W-1:0] x;

  assign out_free = !result_valid || !result_stall;
  assign pop      = (st == ST_IDLE) && !qstat.empty;
  assign x        = CMP_W'(cur.rbc) - cfg.t_cs;

  // edge tests on each side of the parallelogram plus range
  always_comb begin
    hit = cur.in_range
       && !(lhs < cfg.ay_cs_neg)
       && !(lhs > cfg.w_cs)
       && !((cfg.d_pos && cur.bc_neg) || (cfg.d_neg && cur.bc_pos))
       && !((cfg.d_pos && x_pos) || (cfg.d_neg && x_neg));
    tally_next = (hit && (hit_tally < HITS_MAX)) ? hit_tally + 2'd1 : hit_tally;
    finish     = (st == ST_EVAL) && (!cur.last || out_free);
  end

  // sequencer
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: if (pop) st_next = ST_MUL;
      ST_MUL:  st_next = ST_EVAL;
      ST_EVAL: if (finish) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // datapath: latch the entry, then 2*r*q and the depth sign
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (st == ST_MUL) begin
      lhs   <= CMP_W'($signed({1'b0, cur.r, 1'b0})) * CMP_W'(cur.q);
      x_pos <= !x[CMP_W-1] && (x != '0);
      x_neg <= x[CMP_W-1];
    end
  end

  // hit tally
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_tally <= 2'd0;
    end else if (finish) begin
      hit_tally <= cur.last ? 2'd0 : tally_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish && cur.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && cur.last) begin
      result.collision <= (tally_next == HITS_MAX);
      result.hits_seen <= tally_next;
    end
  end

endmodule
